FILE: rtl/dbc_pkg.sv
// Shared types, constants and helpers for the dual button click/hold classifier.
package dbc_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  cfg_ms_t;

    // register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_GAP      = 2'd2,
        REG_DBL_EN   = 2'd3
    } reg_idx_t;

    localparam cfg_ms_t DEBOUNCE_RESET = 16'd50;
    localparam cfg_ms_t HOLD_RESET     = 16'd800;
    localparam cfg_ms_t GAP_RESET      = 16'd250;

    typedef struct packed {
        cfg_ms_t settle_ms;
        cfg_ms_t hold_ms;
        cfg_ms_t double_gap_ms;
        logic    double_click_enable;
    } cfg_t;

    typedef struct packed {
        logic       raw_prev;
        logic       stable;
        time_t      debounce_start;
        time_t      press_start;
        time_t      release_time;
        logic       held_down;
        logic [1:0] clicks;
    } btn_t;

    localparam btn_t BTN_RESET = '{
        raw_prev:       1'b1,
        stable:         1'b1,
        debounce_start: '0,
        press_start:    '0,
        release_time:   '0,
        held_down:      1'b0,
        clicks:         2'd0
    };

    // outcome of one lane, before it is mapped to a button-specific code
    typedef enum logic [1:0] {
        LANE_NONE   = 2'd0,
        LANE_CLICK  = 2'd1,
        LANE_HOLD   = 2'd2,
        LANE_DOUBLE = 2'd3
    } lane_ev_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_LEFT_CLICK   = 3'd1,
        EV_LEFT_HOLD    = 3'd2,
        EV_RIGHT_CLICK  = 3'd3,
        EV_RIGHT_HOLD   = 3'd4,
        EV_RIGHT_DOUBLE = 3'd5
    } event_t;

    function automatic time_t to_time(input logic [31:0] ms);
        to_time = TIME_BITS'(ms);
    endfunction

endpackage

FILE: rtl/dbc_lane.sv
// One button lane: debounce, press timing and click/hold classification.
module dbc_lane (
    input  dbc_pkg::cfg_t     cfg,
    input  dbc_pkg::btn_t     cur,
    input  dbc_pkg::time_t    now,
    input  logic              raw,
    output dbc_pkg::btn_t     nxt,
    output dbc_pkg::lane_ev_t ev
);
    import dbc_pkg::*;

    time_t    db_start;
    time_t    db_elapsed;
    time_t    press_dur;
    time_t    gap_elapsed;
    logic     accept_lvl;
    logic     done_early;
    btn_t     upd;
    lane_ev_t early_ev;
    lane_ev_t resolved;

    assign db_start   = (raw != cur.raw_prev) ? now : cur.debounce_start;
    assign db_elapsed = now - db_start;
    assign accept_lvl = (db_elapsed > TIME_BITS'(cfg.settle_ms)) && (raw != cur.stable);
    assign press_dur  = now - cur.press_start;

    always_comb
    begin
        upd                = cur;
        upd.debounce_start = db_start;
        done_early         = 1'b0;
        early_ev           = LANE_NONE;
        if (accept_lvl)
        begin
            upd.stable = raw;
            if (!raw)
            begin
                upd.press_start = now;
                upd.held_down   = 1'b1;
                if (cur.clicks != 2'd3)
                begin
                    upd.clicks = cur.clicks + 2'd1;
                end
            end
            else if (cur.held_down)
            begin
                upd.held_down    = 1'b0;
                upd.release_time = now;
                if (press_dur >= TIME_BITS'(cfg.hold_ms))
                begin
                    upd.clicks = 2'd0;
                    early_ev   = LANE_HOLD;
                    done_early = 1'b1;
                end
                else if (!cfg.double_click_enable)
                begin
                    upd.clicks = 2'd0;
                    early_ev   = LANE_CLICK;
                    done_early = 1'b1;
                end
            end
        end
    end

    assign gap_elapsed = now - upd.release_time;

    // early exit keeps raw_prev and skips click resolution
    always_comb
    begin
        nxt = upd;
        if (!done_early)
        begin
            if (cfg.double_click_enable && !upd.held_down && (upd.clicks != 2'd0)
                && (gap_elapsed > TIME_BITS'(cfg.double_gap_ms)))
            begin
                nxt.clicks = 2'd0;
            end
            nxt.raw_prev = raw;
        end
    end

    always_comb
    begin
        resolved = LANE_NONE;
        if (!done_early && cfg.double_click_enable && !upd.held_down
            && (upd.clicks != 2'd0) && (gap_elapsed > TIME_BITS'(cfg.double_gap_ms)))
        begin
            resolved = (upd.clicks == 2'd1) ? LANE_CLICK : LANE_DOUBLE;
        end
    end

    assign ev = done_early ? early_ev : resolved;
endmodule

FILE: rtl/dbc_merge.sv
// Merges the two lane outcomes into one event code; left has priority.
module dbc_merge (
    input  dbc_pkg::lane_ev_t left_ev,
    input  dbc_pkg::lane_ev_t right_ev,
    output dbc_pkg::event_t   event_code,
    output logic              right_commit
);
    import dbc_pkg::*;

    event_t left_code;
    event_t right_code;

    always_comb
    begin
        case (left_ev)
            LANE_CLICK: left_code = EV_LEFT_CLICK;
            LANE_HOLD:  left_code = EV_LEFT_HOLD;
            default:    left_code = EV_NONE;   // left double yields nothing
        endcase
    end

    always_comb
    begin
        case (right_ev)
            LANE_CLICK:  right_code = EV_RIGHT_CLICK;
            LANE_HOLD:   right_code = EV_RIGHT_HOLD;
            LANE_DOUBLE: right_code = EV_RIGHT_DOUBLE;
            default:     right_code = EV_NONE;
        endcase
    end

    assign right_commit = (left_code == EV_NONE);
    assign event_code   = right_commit ? right_code : left_code;
endmodule

FILE: rtl/dual_button_click_hold_classifier.sv
// Dual button click/hold classifier top level: config port, lanes, merge and output register.
// Takes one poll per clock cycle while in_ready is high; the event for a poll appears in the
// output register the cycle after the poll beat is accepted. Both button lanes evaluate the
// poll in parallel in combinational compare-and-update logic against their stored state,
// and the merge gives the left button priority: when the left lane reports a click or hold,
// the right lane's state is not updated for that poll. A new poll is taken whenever the
// output register is empty or is being drained in the same cycle. Configuration is to be
// written through the APB port only while the block is idle; the block does not enforce it.
// Writing the double-click enable register clears both click counts.
module dual_button_click_hold_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbc_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [dbc_pkg::DATA_BITS-1:0]   pwdata,
    output logic [dbc_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     now_ms,
    input  logic                            left_level,
    input  logic                            right_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      event_code
);
    import dbc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    btn_t     left_reg;
    btn_t     left_next;
    btn_t     right_reg;
    btn_t     right_next;
    btn_t     left_lane_nxt;
    btn_t     right_lane_nxt;
    lane_ev_t left_ev;
    lane_ev_t right_ev;
    event_t   merged_code;
    logic     right_commit;
    logic     out_valid_reg;
    logic     out_valid_next;
    event_t   event_code_reg;
    logic     in_beat;
    logic     cfg_wr;
    reg_idx_t wr_idx;
    reg_idx_t rd_idx;
    time_t    now_t;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wr_idx  = reg_idx_t'(paddr[3:2]);
    assign rd_idx  = reg_idx_t'(paddr[3:2]);
    assign now_t   = to_time(now_ms);

    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat  = in_valid && in_ready;

    always_comb
    begin
        unique case (rd_idx)
            REG_DEBOUNCE: prdata = DATA_BITS'(cfg_reg.settle_ms);
            REG_HOLD:     prdata = DATA_BITS'(cfg_reg.hold_ms);
            REG_GAP:      prdata = DATA_BITS'(cfg_reg.double_gap_ms);
            REG_DBL_EN:   prdata = DATA_BITS'(cfg_reg.double_click_enable);
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_DEBOUNCE: cfg_next.settle_ms           = pwdata[CFG_BITS-1:0];
                REG_HOLD:     cfg_next.hold_ms             = pwdata[CFG_BITS-1:0];
                REG_GAP:      cfg_next.double_gap_ms       = pwdata[CFG_BITS-1:0];
                REG_DBL_EN:   cfg_next.double_click_enable = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    dbc_lane u_left (
        .cfg (cfg_reg),
        .cur (left_reg),
        .now (now_t),
        .raw (left_level),
        .nxt (left_lane_nxt),
        .ev  (left_ev)
    );

    dbc_lane u_right (
        .cfg (cfg_reg),
        .cur (right_reg),
        .now (now_t),
        .raw (right_level),
        .nxt (right_lane_nxt),
        .ev  (right_ev)
    );

    dbc_merge u_merge (
        .left_ev      (left_ev),
        .right_ev     (right_ev),
        .event_code   (merged_code),
        .right_commit (right_commit)
    );

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (in_beat)
        begin
            left_next = left_lane_nxt;
            if (right_commit)
            begin
                right_next = right_lane_nxt;
            end
        end
        if (cfg_wr && (wr_idx == REG_DBL_EN))
        begin
            left_next.clicks  = 2'd0;
            right_next.clicks = 2'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_beat)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{settle_ms: DEBOUNCE_RESET, hold_ms: HOLD_RESET,
                               double_gap_ms: GAP_RESET, double_click_enable: 1'b0};
            left_reg      <= BTN_RESET;
            right_reg     <= BTN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            event_code_reg <= merged_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;
endmodule

FILE: test/dual_button_click_hold_classifier_tb.sv
// Self-checking testbench for the dual button click/hold classifier.
module dual_button_click_hold_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbc_pkg::*;

    localparam int LEFT_KEY  = 0;
    localparam int RIGHT_KEY = 1;
    localparam int LONG_HOLD_OFF = 300;

    typedef struct packed {
        logic [31:0] now;
        logic        left;
        logic        right;
    } poll_t;

    typedef struct {
        logic        raw_prev;
        logic        stable;
        logic [31:0] deb_start;
        logic [31:0] press_start;
        logic [31:0] release_at;
        logic        held;
        logic [1:0]  clicks;
    } key_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [31:0]          now_ms = '0;
    logic                 left_level = 1'b1;
    logic                 right_level = 1'b1;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           event_code;

    dual_button_click_hold_classifier u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .left_level  (left_level),
        .right_level (right_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code)
    );

    // predictor state and its copy of the registers
    key_state_t keys [2];
    cfg_ms_t    debounce_set = DEBOUNCE_RESET;
    cfg_ms_t    hold_set     = HOLD_RESET;
    cfg_ms_t    gap_set      = GAP_RESET;
    logic       dbl_mode     = 1'b0;

    poll_t  pending_polls [$];
    event_t expected_events [$];
    poll_t  shown_poll;
    logic   presenting = 1'b0;
    int     mismatches = 0;

    int idle_odds = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    int stall_requests = 0;
    int stalls_served = 0;

    // traffic generator state
    logic [31:0] stim_ms = '0;
    logic        gen_level [2];
    int          gen_rem [2];

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * 400_000);
        $display("dual_button_click_hold_classifier_tb: FAIL");
        $finish;
    end

    function automatic lane_ev_t step_key(inout key_state_t k, input logic [31:0] now,
                                          input logic raw);
        logic [31:0] dur;
        logic [31:0] since;
        lane_ev_t    ev;
        ev = LANE_NONE;
        if (raw != k.raw_prev)
            k.deb_start = now;
        since = now - k.deb_start;
        if (since > {16'd0, debounce_set} && raw != k.stable) begin
            k.stable = raw;
            if (!raw) begin
                k.press_start = now;
                k.held = 1'b1;
                if (k.clicks != 2'd3)
                    k.clicks = k.clicks + 2'd1;
            end else if (k.held) begin
                dur = now - k.press_start;
                k.held = 1'b0;
                k.release_at = now;
                // hold or instant click returns before raw_prev is updated
                if (dur >= {16'd0, hold_set}) begin
                    k.clicks = 2'd0;
                    return LANE_HOLD;
                end
                if (!dbl_mode) begin
                    k.clicks = 2'd0;
                    return LANE_CLICK;
                end
            end
        end
        since = now - k.release_at;
        if (dbl_mode && !k.held && k.clicks != 2'd0 && since > {16'd0, gap_set}) begin
            ev = (k.clicks == 2'd1) ? LANE_CLICK : LANE_DOUBLE;
            k.clicks = 2'd0;
        end
        k.raw_prev = raw;
        return ev;
    endfunction

    function automatic event_t classify_poll(input poll_t p);
        lane_ev_t lev;
        lane_ev_t rev;
        lev = step_key(keys[LEFT_KEY], p.now, p.left);
        if (lev == LANE_CLICK)
            return EV_LEFT_CLICK;
        if (lev == LANE_HOLD)
            return EV_LEFT_HOLD;
        // a left double gives nothing, so the right button still runs
        rev = step_key(keys[RIGHT_KEY], p.now, p.right);
        case (rev)
            LANE_CLICK:  return EV_RIGHT_CLICK;
            LANE_HOLD:   return EV_RIGHT_HOLD;
            LANE_DOUBLE: return EV_RIGHT_DOUBLE;
            default:     return EV_NONE;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // driver: one poll beat per handshake
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_events.push_back(classify_poll(shown_poll));
                presenting = 1'b0;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_polls.size() != 0) begin
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                        send_gap = $urandom_range(0, 6);
                        in_valid <= 1'b0;
                    end else begin
                        shown_poll = pending_polls.pop_front();
                        presenting = 1'b1;
                        in_valid <= 1'b1;
                        now_ms <= shown_poll.now;
                        left_level <= shown_poll.left;
                        right_level <= shown_poll.right;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat, then decide on back-pressure
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0)
                    report_mismatch("result with nothing pending", -1, event_code);
                else if (event_code !== expected_events[0]) begin
                    report_mismatch("event_code", expected_events[0], event_code);
                    void'(expected_events.pop_front());
                end else
                    void'(expected_events.pop_front());
            end
            if (stalls_served != stall_requests) begin
                stalls_served++;
                hold_off = LONG_HOLD_OFF;
            end
            if (hold_off > 0) begin
                hold_off--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                recv_gap = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_poll(input logic [31:0] now, input logic l, input logic r);
        pending_polls.push_back('{now: now, left: l, right: r});
    endtask

    task automatic wait_quiet();
        while (pending_polls.size() != 0 || presenting || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] word);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'({idx, 2'b00});
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DEBOUNCE: debounce_set = word[15:0];
            REG_HOLD:     hold_set = word[15:0];
            REG_GAP:      gap_set = word[15:0];
            REG_DBL_EN: begin
                dbl_mode = word[0];
                keys[LEFT_KEY].clicks = 2'd0;
                keys[RIGHT_KEY].clicks = 2'd0;
            end
            default: ;
        endcase
    endtask

    // upper bits carry junk to check that only the low field is kept
    task automatic set_timing(input int db, input int hd, input int gp);
        write_reg(REG_DEBOUNCE, {16'($urandom), 16'(db)});
        write_reg(REG_HOLD, {16'($urandom), 16'(hd)});
        write_reg(REG_GAP, {16'($urandom), 16'(gp)});
    endtask

    task automatic set_mode(input logic dbl);
        write_reg(REG_DBL_EN, {31'($urandom), dbl});
    endtask

    function automatic int next_span(input logic level, input int smax);
        int db;
        int hd;
        int gp;
        db = debounce_set;
        hd = hold_set;
        gp = gap_set;
        if (!level) begin
            if ($urandom_range(0, 1) == 1)
                return db + smax + $urandom_range(0, hd);
            return db + hd + $urandom_range(smax, hd / 2 + 2 * smax);
        end
        // short release gaps build up multi-click runs
        if ($urandom_range(0, 1) == 1)
            return db + $urandom_range(1, gp + smax);
        return db + gp + $urandom_range(smax, 3 * smax + gp);
    endfunction

    task automatic run_traffic(input int n_items);
        int   smax;
        int   step;
        logic raw [2];
        smax = debounce_set / 3 + 2;
        if ((hold_set + gap_set) / 40 > smax)
            smax = (hold_set + gap_set) / 40;
        for (int b = 0; b < 2; b++) begin
            gen_level[b] = 1'b1;
            gen_rem[b] = $urandom_range(1, 4 * smax);
        end
        repeat (n_items) begin
            if ($urandom_range(0, 49) == 0) begin
                // noise: jump anywhere in time with arbitrary levels
                stim_ms = $urandom;
                push_poll(stim_ms, 1'($urandom), 1'($urandom));
            end else begin
                step = $urandom_range(1, smax);
                stim_ms = stim_ms + 32'(step);
                for (int b = 0; b < 2; b++) begin
                    if (gen_rem[b] <= step) begin
                        gen_level[b] = !gen_level[b];
                        gen_rem[b] = next_span(gen_level[b], smax);
                    end else begin
                        gen_rem[b] -= step;
                    end
                    raw[b] = gen_level[b] ^ ($urandom_range(0, 19) == 0);
                end
                push_poll(stim_ms, raw[LEFT_KEY], raw[RIGHT_KEY]);
            end
        end
    endtask

    initial begin
        for (int b = 0; b < 2; b++)
            keys[b] = '{raw_prev: 1'b1, stable: 1'b1, deb_start: '0, press_start: '0,
                        release_at: '0, held: 1'b0, clicks: 2'd0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        idle_odds <= 5;
        @(posedge clk);

        // reset settings: both pressed, left hold masks right, release after early return
        push_poll(32'd0, 1'b1, 1'b1);
        push_poll(32'd10, 1'b0, 1'b0);
        push_poll(32'd70, 1'b0, 1'b0);
        push_poll(32'd900, 1'b1, 1'b1);
        push_poll(32'd960, 1'b1, 1'b1);
        push_poll(32'd1100, 1'b1, 1'b1);
        push_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
        // right press across the time wrap
        push_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
        push_poll(32'h0000_0020, 1'b1, 1'b1);
        push_poll(32'h0000_0060, 1'b1, 1'b1);
        wait_quiet();

        // counting mode: two left clicks, four right clicks, resolved in one poll
        set_mode(1'b1);
        set_timing(0, 800, 100);
        for (int k = 0; k < 16; k++)
            push_poll(32'h1000 + 32'(k), (k < 8) ? k[1] : 1'b1, k[1]);
        push_poll(32'h1100, 1'b1, 1'b1);
        wait_quiet();

        set_mode(1'b0);
        set_timing(20, 300, 150);
        run_traffic(150);
        wait_quiet();

        // long output stall while polls keep coming
        set_mode(1'b1);
        set_timing($urandom_range(0, 60), $urandom_range(200, 900), $urandom_range(80, 300));
        stall_requests <= stall_requests + 1;
        run_traffic(200);
        wait_quiet();

        idle_odds <= 0;
        set_timing(0, 0, 0);
        run_traffic(80);
        wait_quiet();

        idle_odds <= 4;
        set_timing(65535, 65535, 65535);
        stim_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
        run_traffic(80);
        wait_quiet();

        set_timing($urandom_range(0, 100), $urandom_range(50, 1500), $urandom_range(0, 500));
        stim_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
        run_traffic(200);
        wait_quiet();

        // last part runs without idling
        idle_odds <= 0;
        set_mode(1'b0);
        set_timing($urandom_range(0, 80), $urandom_range(0, 1000), $urandom_range(0, 400));
        run_traffic(180);
        wait_quiet();

        if (mismatches == 0)
            $display("dual_button_click_hold_classifier_tb: PASS");
        else
            $display("dual_button_click_hold_classifier_tb: FAIL");
        $finish;
    end

endmodule
